@@ rtl/core/kdf_pkg.sv @@
// shared types and constants for the debounced keypad with key fifo
`timescale 1ns / 1ps
`default_nettype none

package kdf_pkg;

  localparam int NUM_KEYS       = 12;
  localparam int FIFO_DEPTH_DEF = 256;
  localparam int TICKS_W        = 8;
  localparam int CODE_W         = 8;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd100;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  // ascii codes by key index, row by row: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
  localparam logic [CODE_W-1:0] KEY_CODES [NUM_KEYS] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h2A, 8'h30, 8'h23
  };

  // classified item handed from the scanner to the fifo side
  typedef struct packed {
    op_t              op;
    logic             push;
    logic [CODE_W-1:0] push_code;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/kdf_front.sv @@
// front end: per-key debounce timers and latches, classifies each item
`timescale 1ns / 1ps
`default_nettype none

module kdf_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic [kdf_pkg::TICKS_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  input  wire logic [1:0]                  in_op,
  input  wire logic [kdf_pkg::NUM_KEYS-1:0] in_sample,
  input  wire logic                        cmd_ready,
  output kdf_pkg::cmd_t                    cmd
);
  import kdf_pkg::*;

  logic [TICKS_W-1:0] ticks_r;
  logic               latched_r [NUM_KEYS];
  logic               latched_nxt [NUM_KEYS];
  logic [TICKS_W-1:0] timer_r [NUM_KEYS];
  logic [TICKS_W-1:0] timer_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0] hit;
  logic               single;
  logic               update;
  op_t                op;
  logic [CODE_W-1:0]  code_or;

  assign op     = op_t'(in_op);
  // zero or one key down
  assign single = (in_sample & (in_sample - NUM_KEYS'(1))) == '0;
  assign update = in_valid && cmd_ready && (op != OP_FLUSH) && single;

  always_comb begin
    code_or = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hit[k]         = in_sample[k] && !latched_r[k] && (timer_r[k] >= ticks_r);
      latched_nxt[k] = latched_r[k];
      timer_nxt[k]   = timer_r[k];
      if (hit[k]) begin
        code_or = code_or | KEY_CODES[k];
      end
      if (update) begin
        if (!in_sample[k]) begin
          latched_nxt[k] = 1'b0;
          timer_nxt[k]   = '0;
        end else if (!latched_r[k]) begin
          if (hit[k]) begin
            latched_nxt[k] = 1'b1;
          end else begin
            timer_nxt[k] = timer_r[k] + TICKS_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    cmd.op        = op;
    cmd.push      = single && (op != OP_FLUSH) && (|hit);
    cmd.push_code = code_or;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        latched_r[k] <= 1'b0;
        timer_r[k]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        ticks_r <= cfg_data;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        latched_r[k] <= latched_nxt[k];
        timer_r[k]   <= timer_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kdf_queue.sv @@
// two-entry queue between the scanner and the fifo side
`timescale 1ns / 1ps
`default_nettype none

module kdf_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire kdf_pkg::cmd_t push_cmd,
  output logic       push_ready,
  input  wire logic  pop,
  output logic       pop_valid,
  output kdf_pkg::cmd_t pop_cmd
);
  import kdf_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kdf_back.sv @@
// back end: key fifo storage, read/peek/flush and the result register
`timescale 1ns / 1ps
`default_nettype none

module kdf_back #(
  parameter int FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_valid,
  input  wire kdf_pkg::cmd_t              cmd,
  output logic                            cmd_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_key_valid,
  output logic [kdf_pkg::CODE_W-1:0]      out_key_code,
  output logic                            out_has_key,
  output logic                            out_overflow
);
  import kdf_pkg::*;

  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

  logic [CODE_W-1:0] key_mem_r [FIFO_DEPTH];
  logic [CODE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, count_pushed;
  logic              out_valid_r;
  logic              key_valid_r, bypass_r, has_key_r, ovf_r;
  logic [CODE_W-1:0] byp_code_r;

  logic take, is_flush, do_push, dropped, do_rd, bypass, do_pop, mem_rd;

  assign take      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = !out_valid_r || out_ready;

  always_comb begin
    is_flush     = (cmd.op == OP_FLUSH);
    do_push      = take && !is_flush && cmd.push && (count_r != FULL_CNT);
    dropped      = take && !is_flush && cmd.push && (count_r == FULL_CNT);
    count_pushed = count_r + CNT_W'(do_push);
    do_rd        = take && ((cmd.op == OP_READ) || (cmd.op == OP_PEEK))
                   && (count_pushed != '0);
    // empty fifo that just took a key: the head is that key
    bypass       = do_rd && (count_r == '0);
    mem_rd       = do_rd && !bypass;
    do_pop       = do_rd && (cmd.op == OP_READ);

    wr_idx_nxt = wr_idx_r;
    if (do_push) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IDX_W'(1);
    end
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_pushed - CNT_W'(do_pop);
    if (take && is_flush) begin
      rd_idx_nxt = wr_idx_r;
      count_nxt  = '0;
    end else if (do_pop) begin
      rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      key_mem_r[wr_idx_r] <= cmd.push_code;
    end
    if (mem_rd) begin
      rd_data_r <= key_mem_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_valid_r <= do_rd;
      bypass_r    <= bypass;
      byp_code_r  <= cmd.push_code;
      has_key_r   <= (count_nxt != '0);
      ovf_r       <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      count_r  <= count_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_valid = key_valid_r;
  assign out_key_code  = !key_valid_r ? '0 : (bypass_r ? byp_code_r : rd_data_r);
  assign out_has_key   = has_key_r;
  assign out_overflow  = ovf_r;

endmodule

`default_nettype wire

@@ rtl/core/keypad_debounce_fifo_core.sv @@
// top level: debounced 4x3 keypad scanner feeding a key fifo
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tuser op, tdata key_sample
//  out_     out  out_tvalid/out_tready tuser key_valid, tdata code/has_key/overflow
//  cfg_     in   cfg_valid/cfg_ready   cfg_data = debounce_ticks
//
// one item per cycle sustained while neither side stalls; a result is registered
// as the item leaves the two-entry queue; the key fifo memory read is registered.
// synchronous active-low reset clears latches, timers, fifo pointers and
// queue; fifo contents are not cleared. the scanner stalls only when the
// queue is full, the fifo side only when the result register is not taken.
`timescale 1ns / 1ps
`default_nettype none

module keypad_debounce_fifo_core #(
  parameter int FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] key_sample
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] key_code, [8] has_key, [9] overflow
  output logic [0:0]       out_tuser,  // [0] key_valid
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import kdf_pkg::*;

  cmd_t              front_cmd;
  cmd_t              back_cmd;
  logic              q_ready;
  logic              q_valid;
  logic              back_ready;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;
  logic              has_key;
  logic              overflow;

  assign cfg_ready = 1'b1;
  assign in_tready = q_ready;

  kdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_sample (in_tdata[NUM_KEYS-1:0]),
    .cmd_ready (q_ready),
    .cmd       (front_cmd)
  );

  kdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_cmd   (front_cmd),
    .push_ready (q_ready),
    .pop        (back_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (back_cmd)
  );

  kdf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd           (back_cmd),
    .cmd_ready     (back_ready),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_key_valid (key_valid),
    .out_key_code  (key_code),
    .out_has_key   (has_key),
    .out_overflow  (overflow)
  );

  assign out_tdata = {6'd0, overflow, has_key, key_code};
  assign out_tuser = key_valid;

endmodule

`default_nettype wire

@@ dv/keypad_debounce_fifo_core_tb.sv @@
// testbench for the debounced keypad scanner with key fifo, self-checking against its own predictor
`timescale 1ns / 1ps

module keypad_debounce_fifo_core_tb;
  import kdf_pkg::*;

  localparam int FIFO_DEPTH  = 256;
  localparam int N_KEYS      = 12;
  localparam int HOLDOFF_LEN = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 6;

  // ascii code per key, row by row
  localparam logic [7:0] KEY_ASCII [N_KEYS] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "0", "#"
  };

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
    logic       has_key;
    logic       overflow;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [11:0] key_sample
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] key_code, [8] has_key, [9] overflow
  logic [0:0]  out_tuser;       // [0] key_valid
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // predictor state
  logic [7:0]  debounce_ticks;
  logic        key_latched [N_KEYS];
  logic [7:0]  key_timer [N_KEYS];
  logic [7:0]  stored_keys [$];
  key_result_t expected_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  int  holdoff_req = 0;
  int  holdoff_seen = 0;
  int  holdoff_left = 0;

  keypad_debounce_fifo_core #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keypad_debounce_fifo_core test failed");
      $finish;
    end
  end

  // one debounce pass over the sample; returns 1 when a latched key found the fifo full
  function automatic logic debounce_update(logic [11:0] sample);
    logic dropped;
    dropped = 1'b0;
    if ($countones(sample) > 1) return 1'b0;
    for (int k = 0; k < N_KEYS; k++) begin
      if (!sample[k]) begin
        key_latched[k] = 1'b0;
        key_timer[k]   = '0;
      end else if (!key_latched[k]) begin
        if (key_timer[k] >= debounce_ticks) begin
          key_latched[k] = 1'b1;
          if (stored_keys.size() < FIFO_DEPTH) stored_keys.push_back(KEY_ASCII[k]);
          else dropped = 1'b1;
        end else begin
          key_timer[k] = key_timer[k] + 8'd1;
        end
      end
    end
    return dropped;
  endfunction

  function automatic key_result_t keypad_item_result(op_t op, logic [11:0] sample);
    key_result_t r;
    r = '0;
    if (op == OP_FLUSH) begin
      stored_keys.delete();
    end else begin
      r.overflow = debounce_update(sample);
      if ((op == OP_READ || op == OP_PEEK) && stored_keys.size() > 0) begin
        r.key_valid = 1'b1;
        r.key_code  = stored_keys[0];
        if (op == OP_READ) void'(stored_keys.pop_front());
      end
    end
    r.has_key = (stored_keys.size() > 0);
    return r;
  endfunction

  task automatic send_item(input op_t op, input logic [11:0] sample);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, sample};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(keypad_item_result(op, sample));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [7:0] ticks);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    debounce_ticks = ticks;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic op_t random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return OP_SCAN;
    if (r < 80) return OP_READ;
    if (r < 95) return OP_PEEK;
    return OP_FLUSH;
  endfunction

  // receiver: random idling, plus a long hold-off whenever a test requests one
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    key_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata %0h tuser %0h", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.key_valid) begin
          $error("key_valid expected %0d got %0d", want.key_valid, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata[7:0] !== want.key_code) begin
          $error("key_code expected %0h got %0h", want.key_code, out_tdata[7:0]);
          mismatch_count++;
        end
        if (out_tdata[8] !== want.has_key) begin
          $error("has_key expected %0d got %0d", want.has_key, out_tdata[8]);
          mismatch_count++;
        end
        if (out_tdata[9] !== want.overflow) begin
          $error("overflow expected %0d got %0d", want.overflow, out_tdata[9]);
          mismatch_count++;
        end
      end
    end
  end

  // debounce at the reset setting, no register write yet
  task automatic test_reset_setting();
    for (int i = 0; i < 100; i++) send_item(OP_SCAN, 12'h010);
    send_item(OP_PEEK, 12'h010);
    send_item(OP_READ, 12'h010);
    send_item(OP_SCAN, 12'h000);
    drain_results();
  endtask

  // every key, every op, several keys at once, empty reads, flush
  task automatic test_keys_and_ops();
    write_debounce(8'd0);
    for (int k = 0; k < N_KEYS; k++) begin
      send_item((k % 2) ? OP_PEEK : OP_SCAN, 12'(1 << k));
      send_item(OP_SCAN, 12'h000);
    end
    send_item(OP_SCAN, 12'hFFF);
    send_item(OP_READ, 12'h000);
    send_item(OP_PEEK, 12'h000);
    send_item(OP_FLUSH, 12'h001);
    send_item(OP_READ, 12'h000);
    send_item(OP_PEEK, 12'h000);
    drain_results();
  endtask

  // fill the fifo to the brim under a long receiver hold-off, then overflow it
  task automatic test_fifo_full();
    write_debounce(8'd0);
    holdoff_req++;
    for (int i = 0; i < FIFO_DEPTH; i++) send_item(OP_SCAN, 12'(1 << (i % N_KEYS)));
    send_item(OP_SCAN, 12'h800);
    // held key does not retry
    send_item(OP_SCAN, 12'h800);
    send_item(OP_READ, 12'h800);
    send_item(OP_SCAN, 12'h000);
    send_item(OP_PEEK, 12'h400);
    send_item(OP_SCAN, 12'h200);
    send_item(OP_FLUSH, 12'h000);
    send_item(OP_PEEK, 12'h000);
    drain_results();
  endtask

  // setting lowered below a running timer latches on the next pressed sample
  task automatic test_lowered_setting();
    write_debounce(8'd20);
    for (int i = 0; i < 10; i++) send_item(OP_SCAN, 12'h004);
    write_debounce(8'd4);
    send_item(OP_SCAN, 12'h004);
    send_item(OP_READ, 12'h004);
    send_item(OP_SCAN, 12'h000);
    drain_results();
  endtask

  // largest setting: timer runs to 255 without wrapping
  task automatic test_max_setting();
    write_debounce(8'd255);
    for (int i = 0; i < 256; i++) send_item(OP_SCAN, 12'h800);
    send_item(OP_READ, 12'h800);
    send_item(OP_READ, 12'h800);
    send_item(OP_SCAN, 12'h000);
    drain_results();
  endtask

  // mostly clean press and release runs with random ops, some bounce and noise
  task automatic test_random_presses(input int n_items, input logic [7:0] ticks);
    int          sent;
    int          kind;
    int          key;
    int          len;
    logic [11:0] sample;
    sent = 0;
    write_debounce(ticks);
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        key = $urandom_range(0, N_KEYS - 1);
        len = $urandom_range(1, int'(ticks) + 4);
        for (int i = 0; i < len; i++) begin
          sample = 12'(1 << key);
          // occasional bounce or second key
          if ($urandom_range(0, 99) < 5) sample = '0;
          else if ($urandom_range(0, 99) < 5) sample |= 12'(1 << $urandom_range(0, 11));
          send_item(random_op(), sample);
        end
        sent += len;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_item(random_op(), 12'h000);
        sent += len;
      end else begin
        send_item(random_op(), 12'($urandom()));
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    debounce_ticks = TICKS_RESET;
    for (int k = 0; k < N_KEYS; k++) begin
      key_latched[k] = 1'b0;
      key_timer[k]   = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_setting();
    test_keys_and_ops();
    test_fifo_full();
    test_lowered_setting();
    test_max_setting();
    test_random_presses(140, 8'd0);
    test_random_presses(140, 8'd1);
    no_idle = 1'b1;
    test_random_presses(140, 8'd3);
    no_idle = 1'b0;
    test_random_presses(140, 8'd2);
    test_random_presses(140, 8'($urandom_range(4, 12)));
    test_random_presses(140, 8'd7);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keypad_debounce_fifo_core test passed");
    end else begin
      $display("keypad_debounce_fifo_core test failed");
    end
    $finish;
  end

endmodule
